>>> rtl/sfv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_pkg: shared constants and types
// Sizes, command and register codes, and the controller to datapath bundles
// of the stereo FIR and volume unit.
// ----------------------------------------------------------------------------
package sfv_pkg;

	localparam int TAPS        = 32;
	localparam int SAMPLE_BITS = 24;
	localparam int NCH         = 2;
	localparam int COEF_BITS   = 32;
	localparam int COEF_DEPTH  = 2 * TAPS;
	localparam int COEF_AW     = $clog2(COEF_DEPTH);
	localparam int TAP_BITS    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int IDX_BITS    = 6;
	localparam int LEVEL_BITS  = 16;
	localparam int FIR_SHIFT   = 31;
	localparam int LEVEL_SHIFT = 15;
	localparam int ACC_W       = SAMPLE_BITS + FIR_SHIFT;
	localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
	localparam int DRAIN_CYC   = 2;

	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 16'h8000;

	// apb register file
	localparam int APB_AW       = 4;
	localparam int APB_DW       = 32;
	localparam int REG_IDX_BITS = APB_AW - 2;

	localparam logic [REG_IDX_BITS-1:0] REG_FILTER_ENABLE = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_LEFT_LEVEL    = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_RIGHT_LEVEL   = 2'd2;

	// item command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_COEFF = 2'd2;

	typedef struct packed {
		logic                shift_in;
		logic                clear_lines;
		logic                coef_we;
		logic                issue;
		logic [TAP_BITS-1:0] tap_idx;
		logic                scale;
		logic                load_out;
		logic                zero_out;
	} sfv_cmd_t;

	typedef struct packed {
		logic out_free;
	} sfv_sts_t;

endpackage
`default_nettype wire

>>> rtl/sfv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_if: item and result channels
// Valid/ready channels carrying one command item in and one stereo result out.
// ----------------------------------------------------------------------------
interface sfv_item_if;
	import sfv_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic [IDX_BITS-1:0]           coeff_index;
	logic signed [COEF_BITS-1:0]   coeff_value;

	modport source (
		output valid, cmd, left_sample, right_sample, coeff_index, coeff_value,
		input  ready
	);
	modport sink (
		input  valid, cmd, left_sample, right_sample, coeff_index, coeff_value,
		output ready
	);
endinterface

interface sfv_result_if;
	import sfv_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (
		output valid, left_out, right_out,
		input  ready
	);
	modport sink (
		input  valid, left_out, right_out,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/sfv_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_regs: configuration registers
// APB slave holding the filter enable and the two channel levels.
// ----------------------------------------------------------------------------
module sfv_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sfv_pkg::APB_AW-1:0]    paddr,
	input  wire logic [sfv_pkg::APB_DW-1:0]    pwdata,
	output      logic [sfv_pkg::APB_DW-1:0]    prdata,
	output      logic                          pready,
	output      logic                          filter_enable,
	output      logic [sfv_pkg::LEVEL_BITS-1:0] left_level,
	output      logic [sfv_pkg::LEVEL_BITS-1:0] right_level
);
	import sfv_pkg::*;

	logic                    filter_enable_q;
	logic [LEVEL_BITS-1:0]   left_level_q;
	logic [LEVEL_BITS-1:0]   right_level_q;
	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    wr_en;

	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			left_level_q    <= '0;
			right_level_q   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FILTER_ENABLE: filter_enable_q <= pwdata[0];
				REG_LEFT_LEVEL:    left_level_q    <= pwdata[LEVEL_BITS-1:0];
				REG_RIGHT_LEVEL:   right_level_q   <= pwdata[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FILTER_ENABLE: prdata = APB_DW'(filter_enable_q);
			REG_LEFT_LEVEL:    prdata = APB_DW'(left_level_q);
			REG_RIGHT_LEVEL:   prdata = APB_DW'(right_level_q);
			default:           prdata = '0;
		endcase
	end

	assign filter_enable = filter_enable_q;
	assign left_level    = left_level_q;
	assign right_level   = right_level_q;

endmodule
`default_nettype wire

>>> rtl/sfv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_ctrl: sequencing controller
// Takes items, steps the tap counter through the MAC pass and schedules the
// level scaling and result load of the datapath.
// ----------------------------------------------------------------------------
module sfv_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic [1:0]        item_cmd,
	input  wire logic              filter_enable,
	input  wire sfv_pkg::sfv_sts_t sts,
	output      logic              item_ready,
	output      sfv_pkg::sfv_cmd_t cmd
);
	import sfv_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_MUL,
		ST_RESULT
	} state_t;

	localparam logic [TAP_BITS-1:0] TAP_LAST   = TAP_BITS'(TAPS - 1);
	localparam logic [TAP_BITS-1:0] DRAIN_LAST = TAP_BITS'(DRAIN_CYC - 1);

	state_t              state_q;
	logic [TAP_BITS-1:0] cnt_q;
	logic                zero_q;
	logic                fire;

	assign item_ready = (state_q == ST_IDLE);
	assign fire       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item_cmd)
							CMD_TICK: begin
								zero_q  <= 1'b0;
								cnt_q   <= '0;
								state_q <= filter_enable ? ST_MAC : ST_SCALE;
							end
							CMD_CLEAR: begin
								zero_q  <= 1'b1;
								state_q <= ST_RESULT;
							end
							default: ;
						endcase
					end
				end
				ST_MAC: begin
					if (cnt_q == TAP_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				// let the last products reach the accumulator
				ST_DRAIN: begin
					if (cnt_q == DRAIN_LAST) begin
						state_q <= ST_SCALE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCALE: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.shift_in    = fire && (item_cmd == CMD_TICK);
		cmd.clear_lines = fire && (item_cmd == CMD_CLEAR);
		cmd.coef_we     = fire && (item_cmd == CMD_COEFF);
		cmd.issue       = (state_q == ST_MAC);
		cmd.tap_idx     = cnt_q;
		cmd.scale       = (state_q == ST_SCALE);
		cmd.load_out    = (state_q == ST_RESULT) && sts.out_free;
		cmd.zero_out    = zero_q;
	end

endmodule
`default_nettype wire

>>> rtl/sfv_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_dp: filter and scaling datapath
// Per-channel delay lines, coefficient memory, two MAC lanes whose
// multipliers are reused for level scaling, and the result register.
// ----------------------------------------------------------------------------
module sfv_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sfv_pkg::sfv_cmd_t                   cmd,
	output      sfv_pkg::sfv_sts_t                   sts,
	input  wire logic                                filter_enable,
	input  wire logic [sfv_pkg::LEVEL_BITS-1:0]      left_level,
	input  wire logic [sfv_pkg::LEVEL_BITS-1:0]      right_level,
	input  wire logic signed [sfv_pkg::SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [sfv_pkg::SAMPLE_BITS-1:0] right_sample,
	input  wire logic [sfv_pkg::IDX_BITS-1:0]        coeff_index,
	input  wire logic signed [sfv_pkg::COEF_BITS-1:0] coeff_value,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic signed [sfv_pkg::SAMPLE_BITS-1:0] left_out,
	output      logic signed [sfv_pkg::SAMPLE_BITS-1:0] right_out
);
	import sfv_pkg::*;

	logic signed [SAMPLE_BITS-1:0] line_q   [NCH][TAPS];
	logic signed [COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0]         coef_vld_q;

	logic signed [COEF_BITS-1:0]   rd_s1    [NCH];
	logic                          rd_vld_s1 [NCH];
	logic signed [SAMPLE_BITS-1:0] opa_s1   [NCH];
	logic signed [COEF_BITS-1:0]   gain_s1  [NCH];
	logic                          mac_v_s1;
	logic                          gain_sel_s1;
	logic                          mac_v_s2;
	logic signed [PROD_W-1:0]      prod_s2  [NCH];
	logic signed [ACC_W-1:0]       acc_q    [NCH];
	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_q    [NCH];

	logic                          wr_ok;
	logic [COEF_AW-1:0]            wr_addr;
	logic [COEF_AW-1:0]            rd_addr  [NCH];
	logic signed [SAMPLE_BITS-1:0] new_smp  [NCH];
	logic signed [SAMPLE_BITS-1:0] scl_op   [NCH];
	logic [LEVEL_BITS-1:0]         level    [NCH];
	logic [LEVEL_BITS-1:0]         gain     [NCH];
	logic signed [COEF_BITS-1:0]   mul_b    [NCH];

	assign wr_ok   = 32'(coeff_index) < 32'(COEF_DEPTH);
	assign wr_addr = COEF_AW'(coeff_index);

	// left lane reads the lower half of the table, right lane the upper half
	assign rd_addr[0] = COEF_AW'(cmd.tap_idx);
	assign rd_addr[1] = COEF_AW'(TAPS) + COEF_AW'(cmd.tap_idx);

	assign new_smp[0] = left_sample;
	assign new_smp[1] = right_sample;
	assign level[0]   = left_level;
	assign level[1]   = right_level;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			gain[c]   = (level[c] > LEVEL_MAX) ? LEVEL_MAX : level[c];
			scl_op[c] = filter_enable ? acc_q[c][FIR_SHIFT +: SAMPLE_BITS] : line_q[c][0];
			if (gain_sel_s1) begin
				mul_b[c] = gain_s1[c];
			end else begin
				mul_b[c] = rd_vld_s1[c] ? rd_s1[c] : '0;
			end
		end
	end

	// delay lines: clear on a clear item, shift on a tick, rotate by one tap per MAC step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				for (int t = 0; t < TAPS; t++) begin
					line_q[c][t] <= '0;
				end
			end
		end else if (cmd.clear_lines) begin
			for (int c = 0; c < NCH; c++) begin
				for (int t = 0; t < TAPS; t++) begin
					line_q[c][t] <= '0;
				end
			end
		end else if (cmd.shift_in) begin
			for (int c = 0; c < NCH; c++) begin
				line_q[c][0] <= new_smp[c];
				for (int t = 1; t < TAPS; t++) begin
					line_q[c][t] <= line_q[c][t-1];
				end
			end
		end else if (cmd.issue) begin
			for (int c = 0; c < NCH; c++) begin
				for (int t = 0; t < TAPS - 1; t++) begin
					line_q[c][t] <= line_q[c][t+1];
				end
				line_q[c][TAPS-1] <= line_q[c][0];
			end
		end
	end

	// coefficient memory, one write port and two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.coef_we && wr_ok) begin
			coef_mem[wr_addr] <= coeff_value;
		end
		for (int c = 0; c < NCH; c++) begin
			rd_s1[c] <= coef_mem[rd_addr[c]];
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (cmd.coef_we && wr_ok) begin
			coef_vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1    <= 1'b0;
			gain_sel_s1 <= 1'b0;
			mac_v_s2    <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			mac_v_s1    <= cmd.issue;
			gain_sel_s1 <= cmd.scale;
			mac_v_s2    <= mac_v_s1;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			if (cmd.issue) begin
				opa_s1[c]    <= line_q[c][0];
				rd_vld_s1[c] <= coef_vld_q[rd_addr[c]];
			end else if (cmd.scale) begin
				opa_s1[c]  <= scl_op[c];
				gain_s1[c] <= COEF_BITS'(gain[c]);
			end
			if (mac_v_s1 || gain_sel_s1) begin
				prod_s2[c] <= opa_s1[c] * mul_b[c];
			end
			if (cmd.shift_in) begin
				acc_q[c] <= '0;
			end else if (mac_v_s2) begin
				acc_q[c] <= acc_q[c] + prod_s2[c][ACC_W-1:0];
			end
			if (cmd.load_out) begin
				out_q[c] <= cmd.zero_out ? '0 : prod_s2[c][LEVEL_SHIFT +: SAMPLE_BITS];
			end
		end
	end

	assign sts.out_free = !out_vld_q || out_ready;
	assign out_valid    = out_vld_q;
	assign left_out     = out_q[0];
	assign right_out    = out_q[1];

endmodule
`default_nettype wire

>>> rtl/stereo_fir_volume_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_fir_volume_unit: stereo FIR filter with volume scaling
// Usage:
//  - item channel (valid/ready) carries a command: sample tick, clear of both
//    delay lines, or a coefficient write into the 64-word table
//  - result channel (valid/ready) returns one left/right pair for each tick
//    and each clear; coefficient writes and unused codes give no result
//  - APB port sets filter enable and the two Q15 levels; write it while idle
//  - a tick with the filter on runs 32 steps of the two MAC lanes (one tap
//    per cycle per channel, paced by the coefficient memory read port), a
//    pipeline drain, then the level scaling on the same multipliers and the
//    load of the result register; the next item is taken once the sequencer
//    is back in idle after the load
//  - with the filter off a tick skips the MAC pass and goes straight to the
//    level scaling; a clear goes straight to the result load, and a
//    coefficient write leaves the sequencer idle
//  - one item is in flight at a time; ready is high whenever the sequencer
//    is idle, even while the previous result still waits in the output
//    register
//  - a stalled receiver holds the result register; a following result waits
//    in the sequencer until the register is taken
//  - reset clears the delay lines, the coefficient valid bits (the table
//    reads as zero), the sequencer and the configuration registers
// ----------------------------------------------------------------------------
module stereo_fir_volume_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sfv_item_if.sink                           item,
	sfv_result_if.source                       result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sfv_pkg::APB_AW-1:0]    paddr,
	input  wire logic [sfv_pkg::APB_DW-1:0]    pwdata,
	output      logic [sfv_pkg::APB_DW-1:0]    prdata,
	output      logic                          pready
);
	import sfv_pkg::*;

	logic                  filter_enable;
	logic [LEVEL_BITS-1:0] left_level;
	logic [LEVEL_BITS-1:0] right_level;
	sfv_cmd_t              ctl_cmd;
	sfv_sts_t              dp_sts;

	sfv_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.filter_enable (filter_enable),
		.left_level    (left_level),
		.right_level   (right_level)
	);

	sfv_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item.valid),
		.item_cmd      (item.cmd),
		.filter_enable (filter_enable),
		.sts           (dp_sts),
		.item_ready    (item.ready),
		.cmd           (ctl_cmd)
	);

	sfv_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.sts           (dp_sts),
		.filter_enable (filter_enable),
		.left_level    (left_level),
		.right_level   (right_level),
		.left_sample   (item.left_sample),
		.right_sample  (item.right_sample),
		.coeff_index   (item.coeff_index),
		.coeff_value   (item.coeff_value),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.left_out      (result.left_out),
		.right_out     (result.right_out)
	);

`ifndef SYNTHESIS
	// a filtered tick goes straight into the MAC pass
	a_tick_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.cmd == CMD_TICK && filter_enable)
		|=> ctl_cmd.issue)
		else $error("filtered tick did not start the MAC pass");

	// a coefficient write leaves the block ready for the next transaction
	a_coef_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.cmd == CMD_COEFF) |=> item.ready)
		else $error("coefficient write left the sequencer busy");

	// datapath commands never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl_cmd.shift_in, ctl_cmd.clear_lines, ctl_cmd.coef_we,
			ctl_cmd.issue, ctl_cmd.scale, ctl_cmd.load_out}))
		else $error("overlapping datapath commands");
`endif

endmodule
`default_nettype wire
